[hdl/wcw_pkg.sv]
// ----------------------------------------------------------------------------
// Waypoint chain window package
// Shared field widths, tdata layout, probe and write bus types, FSM codes.
// ----------------------------------------------------------------------------
package wcw_pkg;

   // field widths
   localparam int ID_W   = 64;
   localparam int PAY_W  = 64;
   localparam int SLOT_W = 8;
   localparam int LEN_W  = 5;
   localparam int CFG_W  = 9;

   // reset value of entries_in_use
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd1;

   // request tdata layout, lowest bit up
   localparam int REQ_SLOT_LO  = 0;
   localparam int REQ_WPID_LO  = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_NEXT_LO  = REQ_WPID_LO + ID_W;
   localparam int REQ_PAY_LO   = REQ_NEXT_LO + ID_W;
   localparam int REQ_START_LO = REQ_PAY_LO + PAY_W;
   localparam int REQ_LEN_LO   = REQ_START_LO + ID_W;
   localparam int REQ_BITS     = REQ_LEN_LO + LEN_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit up
   localparam int RSP_ID_LO   = 0;
   localparam int RSP_NEXT_LO = RSP_ID_LO + ID_W;
   localparam int RSP_PAY_LO  = RSP_NEXT_LO + ID_W;
   localparam int RSP_DATA_W  = RSP_PAY_LO + PAY_W;

   // request kinds carried in req_tuser
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_WINDOW = 1'b1;

   // table write, broadcast to every cell
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   nxt;
      logic [PAY_W-1:0]  payload;
   } wcw_write_type;

   // lookup probe that walks the cell row
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [ID_W-1:0]  key;
      logic [ID_W-1:0]  nxt;
      logic [PAY_W-1:0] payload;
   } wcw_probe_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_LOAD   = 3'b100
   } wcw_state_type;

endpackage

[hdl/waypoint_chain_window_unit.sv]
// ----------------------------------------------------------------------------
// Waypoint chain window unit
// Waypoint table in a row of cells; window requests follow next ids through
// the table and stream out one response per waypoint.
// ----------------------------------------------------------------------------
// Write request: next request taken on the following cycle.
// Window request: each lookup walks the whole cell row, and its result is loaded
//   into the output register once that register is free, so the response side
//   can stall the walk for the next waypoint; the next request is taken in the
//   cycle after the last of L responses is loaded.
// One request is worked on at a time; a final response may wait in the output
//   register while the next request is accepted.
// Reset clears control state and sets entries_in_use to 1; table contents stay
//   undefined until written.
module waypoint_chain_window_unit #(
   parameter int TABLE_DEPTH  = 256,
   parameter int WINDOW_MAX   = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // slot, wp_id, next_id, payload, start_id, window_length
   input  logic [wcw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic                             req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_id, out_next_id, out_payload
   output logic [wcw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   // not_found
   output logic                             rsp_tuser,
   // configuration: entries_in_use
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wcw_pkg::CFG_W-1:0]        csr_data
);

   localparam int WL = $clog2(WINDOW_MAX + 1);

   wcw_pkg::wcw_state_type           state_ff, state_in;
   logic [wcw_pkg::CFG_W-1:0]        limit_ff;
   wcw_pkg::wcw_write_type           wr_ff, wr_in;
   logic                             inject_ff, inject_in;
   logic [wcw_pkg::ID_W-1:0]         key_ff, key_in;
   logic [WL-1:0]                    rem_ff, rem_in;
   wcw_pkg::wcw_probe_type           hold_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wcw_pkg::ID_W-1:0]         rsp_id_ff;
   logic [wcw_pkg::ID_W-1:0]         rsp_next_ff;
   logic [wcw_pkg::PAY_W-1:0]        rsp_pay_ff;
   logic                             rsp_last_ff;
   logic                             rsp_nf_ff;
   wcw_pkg::wcw_probe_type           chain [TABLE_DEPTH+1];
   wcw_pkg::wcw_probe_type           chain_out;

   logic                             req_fire;
   logic                             rsp_fire;
   logic                             load;
   logic                             load_last;
   logic [wcw_pkg::LEN_W-1:0]        req_len;
   logic [31:0]                      len_sat;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= wcw_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // request decode
   assign req_len = req_tdata[wcw_pkg::REQ_LEN_LO +: wcw_pkg::LEN_W];
   assign len_sat = (32'(req_len) > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : 32'(req_len);

   always_comb begin
      wr_in         = '0;
      wr_in.slot    = req_tdata[wcw_pkg::REQ_SLOT_LO +: wcw_pkg::SLOT_W];
      wr_in.id      = req_tdata[wcw_pkg::REQ_WPID_LO +: wcw_pkg::ID_W];
      wr_in.nxt     = req_tdata[wcw_pkg::REQ_NEXT_LO +: wcw_pkg::ID_W];
      wr_in.payload = req_tdata[wcw_pkg::REQ_PAY_LO +: wcw_pkg::PAY_W];
      wr_in.valid   = req_fire && (req_tuser == wcw_pkg::FUNC_WRITE);
   end

   // a held result goes out once the output register is free
   assign load      = (state_ff == wcw_pkg::ST_LOAD) && (!rsp_valid_ff || rsp_tready);
   assign load_last = !hold_ff.found || (rem_ff == WL'(1));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      inject_in = 1'b0;
      key_in    = key_ff;
      rem_in    = rem_ff;
      unique case (state_ff)
         wcw_pkg::ST_IDLE: begin
            if (req_fire && (req_tuser == wcw_pkg::FUNC_WINDOW) && (len_sat != 32'd0)) begin
               key_in    = req_tdata[wcw_pkg::REQ_START_LO +: wcw_pkg::ID_W];
               rem_in    = WL'(len_sat);
               inject_in = 1'b1;
               state_in  = wcw_pkg::ST_SEARCH;
            end
         end
         wcw_pkg::ST_SEARCH: begin
            if (chain_out.valid) begin
               state_in = wcw_pkg::ST_LOAD;
            end
         end
         wcw_pkg::ST_LOAD: begin
            if (load) begin
               if (load_last) begin
                  state_in = wcw_pkg::ST_IDLE;
               end else begin
                  key_in    = hold_ff.nxt;
                  rem_in    = rem_ff - WL'(1);
                  inject_in = 1'b1;
                  state_in  = wcw_pkg::ST_SEARCH;
               end
            end
         end
         default: begin
            state_in = wcw_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == wcw_pkg::ST_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcw_pkg::ST_IDLE;
         inject_ff    <= 1'b0;
         wr_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= inject_in;
         wr_ff.valid  <= wr_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_ff.slot    <= wr_in.slot;
      wr_ff.id      <= wr_in.id;
      wr_ff.nxt     <= wr_in.nxt;
      wr_ff.payload <= wr_in.payload;
      key_ff        <= key_in;
      rem_ff        <= rem_in;
      if (chain_out.valid) begin
         hold_ff <= chain_out;
      end
      if (load) begin
         rsp_id_ff   <= hold_ff.key;
         rsp_next_ff <= load_last ? hold_ff.key : hold_ff.nxt;
         rsp_pay_ff  <= hold_ff.payload;
         rsp_last_ff <= load_last;
         rsp_nf_ff   <= !hold_ff.found;
      end
   end

   // cell row: probe enters at cell zero and leaves after the last cell
   always_comb begin
      chain[0]         = '0;
      chain[0].valid   = inject_ff;
      chain[0].key     = key_ff;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      wcw_cell #(
         .CELL_INDEX   (g),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .limit_i (limit_ff),
         .wr_i    (wr_ff),
         .probe_i (chain[g]),
         .probe_o (chain[g+1])
      );
   end

   assign chain_out = chain[TABLE_DEPTH];

   // response outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pay_ff, rsp_next_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_nf_ff;

   // checks
   a_exit_in_search: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> (state_ff == wcw_pkg::ST_SEARCH))
      else $error("probe left the cell row outside a search");

   a_nf_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("not-found response without last");

   a_window_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == wcw_pkg::FUNC_WINDOW) && (req_len != '0))
      |=> (state_ff == wcw_pkg::ST_SEARCH) && inject_ff)
      else $error("window request did not start a lookup");

   a_load_after_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcw_pkg::ST_SEARCH) && chain_out.valid |=> (state_ff == wcw_pkg::ST_LOAD))
      else $error("lookup result not taken");

endmodule

[hdl/wcw_cell.sv]
// ----------------------------------------------------------------------------
// Waypoint table cell
// Holds one table entry and compares it against the probe passing by; the
// first enabled cell that matches fills in the probe and marks it found.
// ----------------------------------------------------------------------------
module wcw_cell #(
   parameter int CELL_INDEX   = 0,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [wcw_pkg::CFG_W-1:0]   limit_i,
   input  wcw_pkg::wcw_write_type      wr_i,
   input  wcw_pkg::wcw_probe_type      probe_i,
   output wcw_pkg::wcw_probe_type      probe_o
);

   logic [wcw_pkg::ID_W-1:0] id_ff;
   logic [wcw_pkg::ID_W-1:0] next_ff;
   logic [PAYLOAD_BITS-1:0]  pay_ff;
   wcw_pkg::wcw_probe_type   probe_ff;
   wcw_pkg::wcw_probe_type   probe_in;
   logic                     wr_hit;
   logic                     in_use;
   logic                     hit;

   // entry store
   assign wr_hit = wr_i.valid && (32'(wr_i.slot) == 32'(CELL_INDEX));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         id_ff   <= wr_i.id;
         next_ff <= wr_i.nxt;
         pay_ff  <= wr_i.payload[PAYLOAD_BITS-1:0];
      end
   end

   // match: only slots below the in-use count, and only if nobody ahead hit
   assign in_use = 32'(CELL_INDEX) < 32'(limit_i);
   assign hit    = probe_i.valid && !probe_i.found && in_use && (id_ff == probe_i.key);

   always_comb begin
      probe_in = probe_i;
      if (hit) begin
         probe_in.found   = 1'b1;
         probe_in.nxt     = next_ff;
         probe_in.payload = wcw_pkg::PAY_W'(pay_ff);
      end
   end

   // hand the probe to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.found   <= probe_in.found;
      probe_ff.key     <= probe_in.key;
      probe_ff.nxt     <= probe_in.nxt;
      probe_ff.payload <= probe_in.payload;
   end

   assign probe_o = probe_ff;

endmodule
